@@ rtl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial chaining words, action codes and a rotate helper.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigWords   = 8;

  localparam logic [1:0] ActAbsorb = 2'd0;
  localparam logic [1:0] ActLast   = 2'd1;
  localparam logic [1:0] ActFinish = 2'd2;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

@@ rtl/sha_if.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream channels
// Valid/ready channels for input beats and digest beats.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink (input valid, digest_word, word_index, last, output ready);
endinterface

@@ rtl/sha_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 round engine
// One shared round unit, 64 iterations per block, with a rolling 16-word
// schedule window fed from the block memory one word per cycle.
// ----------------------------------------------------------------------------
module sha_core
  import sha_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         reset_chain_i,
  input  logic [31:0]  msg_word_i,
  output logic [3:0]   msg_addr_o,
  output logic         busy_o,
  output logic         done_o,
  output logic [255:0] chain_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFetch = 2'd1;
  localparam logic [1:0] StRound = 2'd2;
  localparam logic [1:0] StAdd   = 2'd3;

  logic [1:0]   state_q, state_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [31:0]  w_q [16];
  logic [31:0]  r_q [8];
  logic [31:0]  h_q [8];
  logic [31:0]  w_cur, w_new, t1, t2, s0, s1;

  assign msg_addr_o = cnt_d[3:0];
  assign busy_o     = (state_q != StIdle);

  always_comb begin
    s0    = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1    = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
    w_cur = (cnt_q < 7'd16) ? msg_word_i : w_new;
    t1 = r_q[7] + (ror(r_q[4], 6) ^ ror(r_q[4], 11) ^ ror(r_q[4], 25))
       + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6])) + round_k(cnt_q[5:0]) + w_cur;
    t2 = (ror(r_q[0], 2) ^ ror(r_q[0], 13) ^ ror(r_q[0], 22))
       + ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_o  = 1'b0;
    case (state_q)
      StIdle: if (start_i) begin
        state_d = StFetch;
        cnt_d   = '0;
      end
      StFetch: state_d = StRound;
      StRound: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(Rounds - 1)) state_d = StAdd;
      end
      StAdd: begin
        state_d = StIdle;
        done_o  = 1'b1;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (reset_chain_i) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
      end else if (state_q == StAdd) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
    end else if (state_q == StRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_cur;
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) chain_o[255-32*i -: 32] = h_q[i];
  end

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Absorbs message bytes, pads on finish, emits eight digest words.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   action, data_byte
//  out_ch   out  digest_word, word_index, last
//
//  A byte that does not complete a block is written to the block memory; a
//  block-completing byte also starts the engine (load, 64 rounds, chain add).
//  Finish writes padding through the block memory one byte a cycle while the
//  engine is idle, runs one or two compressions, then holds eight digest beats.
//  Reset restores the initial chaining value; no clearing pass is needed.
//  Input is not ready while a block compresses, padding is written or the
//  digest drains.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
  import sha_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  sha_in_if.sink   in_ch,
  sha_out_if.source out_ch
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StLen   = 3'd2;
  localparam logic [2:0] StComp  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  bits_q, bits_d;
  logic         final_q, final_d;
  logic         pad_q, pad_d;
  logic [2:0]   widx_q, widx_d;
  logic [31:0]  mem [BlockBytes/4];
  logic [31:0]  rd_word;
  logic         wr_en;
  logic [5:0]   wr_addr;
  logic [7:0]   wr_data;
  logic [3:0]   rd_addr;
  logic         core_start;
  logic         core_busy;
  logic         core_done;
  logic         reset_chain;
  logic [255:0] chain;
  logic         acc;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == StIdle) && !core_busy;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr[5:2]][8*(3-wr_addr[1:0]) +: 8] <= wr_data;
    rd_word <= mem[rd_addr];
  end

  sha_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (core_start),
    .reset_chain_i(reset_chain),
    .msg_word_i   (rd_word),
    .msg_addr_o   (rd_addr),
    .busy_o       (core_busy),
    .done_o       (core_done),
    .chain_o      (chain)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    bits_d      = bits_q;
    final_d     = final_q;
    pad_d       = pad_q;
    widx_d      = widx_q;
    wr_en       = 1'b0;
    wr_addr     = fill_q;
    wr_data     = in_ch.data_byte;
    core_start  = 1'b0;
    reset_chain = 1'b0;
    case (state_q)
      StIdle: if (acc) begin
        if (in_ch.action == ActAbsorb || in_ch.action == ActLast) begin
          wr_en  = 1'b1;
          fill_d = fill_q + 6'd1;
          bits_d = bits_q + 64'd8;
          if (fill_q == 6'd63) core_start = 1'b1;
        end
        if (in_ch.action == ActLast || in_ch.action == ActFinish) begin
          state_d = StPad;
          final_d = 1'b0;
          pad_d   = 1'b0;
          if (in_ch.action == ActLast && fill_q == 6'd63) state_d = StComp;
        end
      end
      StComp: if (core_done) state_d = final_q ? StOut : StPad;
      StPad: if (!core_busy) begin
        wr_en   = 1'b1;
        wr_data = pad_q ? 8'h00 : PadByte;
        fill_d  = fill_q + 6'd1;
        pad_d   = 1'b1;
        if (fill_q == 6'd55) begin
          state_d = StLen;
        end else if (fill_q == 6'd63) begin
          core_start = 1'b1;
          state_d    = StComp;
          final_d    = 1'b0;
        end
      end
      StLen: begin
        wr_en   = 1'b1;
        wr_data = bits_q[8*(7-(fill_q[2:0]))+:8];
        fill_d  = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          core_start = 1'b1;
          state_d    = StComp;
          final_d    = 1'b1;
          widx_d     = '0;
        end
      end
      StOut: if (out_ch.ready) begin
        widx_d = widx_q + 3'd1;
        if (widx_q == 3'd7) begin
          state_d     = StIdle;
          reset_chain = 1'b1;
          bits_d      = '0;
          fill_d      = '0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_ch.valid       = (state_q == StOut);
  assign out_ch.digest_word = chain[255 - 32*widx_q -: 32];
  assign out_ch.word_index  = widx_q;
  assign out_ch.last        = (widx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      bits_q  <= '0;
      final_q <= 1'b0;
      pad_q   <= 1'b0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      final_q <= final_d;
      pad_q   <= pad_d;
      widx_q  <= widx_d;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_busy |-> !in_ch.ready) else $error("input accepted during rounds");
  a_out_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid)
    else $error("digest overrun");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_start |-> !core_busy) else $error("start while busy");

endmodule
